>>> src/lgte_pkg.sv
`default_nettype none

package lgte_pkg;

  // tire slots the alert word has room for
  localparam int TIRE_MAX       = 4;
  localparam int TIRE_COUNT_DEF = 4;

  // stream and register port widths
  localparam int IN_W      = 72;
  localparam int USER_W    = 1;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_DWELL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VER_DWELL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 3'd5;

  // register reset values and limits
  localparam logic [14:0] THR_RESET       = 15'd2867;
  localparam logic [14:0] THR_MIN         = 15'd82;
  localparam logic [15:0] CAP_DWELL_RESET = 16'd500;
  localparam logic [14:0] VER_DWELL_RESET = 15'd2500;

  // axis codes; anything else selects z
  localparam logic [1:0] AXIS_X     = 2'd0;
  localparam logic [1:0] AXIS_Y     = 2'd1;
  localparam logic [1:0] AXIS_RESET = AXIS_Y;

  // word kinds
  localparam logic KIND_TICK = 1'b0;

  // EMA weight in Q8 (0.35 rounded to 90/256)
  localparam logic [6:0] ALPHA_Q8 = 7'd90;

  // verdict codes
  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_OVER  = 2'd1;
  localparam logic [1:0] VERDICT_UNDER = 2'd2;

  // stored condition codes
  localparam logic signed [1:0] COND_NEUTRAL = 2'sb00;
  localparam logic signed [1:0] COND_OVER    = 2'sb01;
  localparam logic signed [1:0] COND_UNDER   = 2'sb11;

  typedef logic signed [16:0] score_t;

  // what the score unit does to the tire in hand
  typedef struct packed {
    logic upd;
    logic clr;
  } score_ctrl_t;

endpackage

`default_nettype wire

>>> src/lgte_score_unit.sv
`default_nettype none

module lgte_score_unit (
  input  lgte_pkg::score_ctrl_t ctrl,
  input  lgte_pkg::score_t      score,
  input  logic signed [1:0]     cond,
  input  logic [14:0]           dt,
  input  logic [14:0]           leak,
  input  logic [14:0]           dwell,
  output lgte_pkg::score_t      score_next,
  output logic [1:0]            alert
);
  import lgte_pkg::*;

  logic signed [17:0] s_ext;
  logic signed [17:0] dt_ext;
  logic signed [17:0] leak_ext;
  logic signed [17:0] cap_pos;
  logic signed [17:0] cap_neg;
  logic signed [17:0] moved;
  logic signed [17:0] clamped;
  logic signed [17:0] result;
  logic signed [17:0] dwell_pos;
  logic signed [17:0] dwell_neg;

  // move by condition, leak when neutral, clamp at twice the dwell; clear or hold per ctrl
  always_comb begin
    s_ext    = {score[16], score};
    dt_ext   = {3'b000, dt};
    leak_ext = {3'b000, leak};
    cap_pos  = {2'b00, dwell, 1'b0};
    cap_neg  = -cap_pos;
    moved    = s_ext;
    if (cond == COND_OVER) begin
      moved = s_ext + dt_ext;
    end else if (cond[1]) begin
      moved = s_ext - dt_ext;
    end else if (s_ext > 18'sd0) begin
      moved = s_ext - leak_ext;
      if (moved < 18'sd0) moved = 18'sd0;
    end else if (s_ext < 18'sd0) begin
      moved = s_ext + leak_ext;
      if (moved > 18'sd0) moved = 18'sd0;
    end
    clamped = moved;
    if (clamped > cap_pos) clamped = cap_pos;
    if (clamped < cap_neg) clamped = cap_neg;
    if (ctrl.clr) begin
      result = 18'sd0;
    end else if (ctrl.upd) begin
      result = clamped;
    end else begin
      result = s_ext;
    end
  end

  assign score_next = result[16:0];

  // verdict on the score as it leaves the unit
  always_comb begin
    dwell_pos = {3'b000, dwell};
    dwell_neg = -dwell_pos;
    if (result >= dwell_pos) begin
      alert = VERDICT_OVER;
    end else if (result <= dwell_neg) begin
      alert = VERDICT_UNDER;
    end else begin
      alert = VERDICT_NONE;
    end
  end

endmodule

`default_nettype wire

>>> src/lateral_gate_tire_evidence.sv
`default_nettype none

// Channel  Group               Fields, lowest bit first
// -------  ------------------  --------------------------------------------------
// in       s_tvalid/tready     tdata: accel_x, accel_y, accel_z, elapsed_ms,
//                              track_mode, tire_index, condition; tuser: kind
// out      m_tvalid/tready     tdata: capturing, lateral_accel, tire_alerts,
//                              overall_alert
// config   cfg_wr_en           cfg_index, cfg_data; taken on every enabled edge
//
// A sample tick passes S_MUL, S_FILT, S_ZONE, then S_TIRE once per tire, then
// S_DONE loads the output register (the seeding tick skips S_FILT); a condition update
// goes straight to the S_TIRE walk through the single score unit.
// s_tready is high only while the sequencer is idle, from the cycle after the load.
// A finished word waits in the output register; the next word may be taken
// meanwhile, and the sequencer holds its result until the register is free.
// rst is synchronous: registers to reset values, scores and conditions zero.

module lateral_gate_tire_evidence #(
  parameter int TIRE_COUNT = lgte_pkg::TIRE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // accel_x, accel_y, accel_z, elapsed_ms, track_mode, tire_index, condition
  input  logic [lgte_pkg::IN_W-1:0]      s_tdata,
  // kind
  input  logic [lgte_pkg::USER_W-1:0]    s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // capturing, lateral_accel, tire_alerts, overall_alert
  output logic [lgte_pkg::OUT_W-1:0]     m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_wr_en,
  input  logic [lgte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgte_pkg::CFG_W-1:0]     cfg_data
);
  import lgte_pkg::*;

  localparam int TIDX_W = (TIRE_COUNT > 1) ? $clog2(TIRE_COUNT) : 1;
  localparam logic [TIDX_W-1:0] LAST_TIRE = TIDX_W'(TIRE_COUNT - 1);
  localparam int ALERT_SHIFT = 2 * (TIRE_MAX - TIRE_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FILT = 3'd2;
  localparam logic [2:0] S_ZONE = 3'd3;
  localparam logic [2:0] S_TIRE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // configuration
  logic               enable;
  logic [14:0]        zone_thr;
  logic [15:0]        cap_dwell;
  logic [14:0]        ver_dwell;
  logic [1:0]         axis;
  logic signed [15:0] bias;

  // block state
  logic signed [24:0] filt;
  logic               seeded;
  logic [15:0]        zone_timer;
  logic               capture;
  score_t             score [TIRE_COUNT];
  logic signed [1:0]  cond  [TIRE_COUNT];

  // sequencer
  logic [2:0]         fsm;
  logic               track_q;
  logic signed [16:0] raw_q;
  logic [14:0]        dt_q;
  logic signed [32:0] prod_q;
  logic [14:0]        leak_q;
  logic               upd_q;
  logic               inert_q;
  logic [TIDX_W-1:0]  cnt;
  logic [7:0]         alerts_acc;
  logic [2:0]         over_cnt;
  logic [2:0]         under_cnt;

  // input word fields
  logic               in_fire;
  logic signed [15:0] accel_x, accel_y, accel_z, elapsed_ms, sel;
  logic               track_mode, kind;
  logic [1:0]         tire_index;
  logic signed [1:0]  condition;
  logic signed [16:0] raw;
  logic [14:0]        dt_clamp;

  assign accel_x    = s_tdata[15:0];
  assign accel_y    = s_tdata[31:16];
  assign accel_z    = s_tdata[47:32];
  assign elapsed_ms = s_tdata[63:48];
  assign track_mode = s_tdata[64];
  assign tire_index = s_tdata[66:65];
  assign condition  = s_tdata[68:67];
  assign kind       = s_tuser[0];

  assign s_tready = (fsm == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // lateral pick, bias removal, negative dt to zero
  always_comb begin
    case (axis)
      AXIS_X:  sel = accel_x;
      AXIS_Y:  sel = accel_y;
      default: sel = accel_z;
    endcase
    raw      = {sel[15], sel} - {bias[15], bias};
    dt_clamp = elapsed_ms[15] ? 15'd0 : elapsed_ms[14:0];
  end

  // EMA step: difference times alpha
  logic signed [24:0] raw_q8;
  logic signed [25:0] diff;
  logic signed [7:0]  alpha_s;
  logic signed [33:0] prod_full;

  always_comb begin
    raw_q8    = {raw_q, 8'b0};
    diff      = {raw_q8[24], raw_q8} - {filt[24], filt};
    alpha_s   = {1'b0, ALPHA_Q8};
    prod_full = diff * alpha_s;
  end

  // zone test, saturating timer, neutral leak
  logic [24:0] mag;
  logic        zone;
  logic [16:0] t_sum;
  logic [15:0] t_next;
  logic        cap_next;
  logic [16:0] dt3;
  logic [14:0] leak_next;

  always_comb begin
    mag       = filt[24] ? 25'(-filt) : 25'(filt);
    zone      = mag < {2'b00, zone_thr, 8'b0};
    t_sum     = {1'b0, zone_timer} + {2'b00, dt_q};
    t_next    = zone ? (t_sum[16] ? 16'hFFFF : t_sum[15:0]) : 16'd0;
    cap_next  = zone && (t_next >= cap_dwell);
    dt3       = {2'b00, dt_q} + {1'b0, dt_q, 1'b0};
    leak_next = (dt3[16:2] == 15'd0) ? 15'd1 : dt3[16:2];
  end

  // shared score unit, one tire a cycle
  score_ctrl_t ctrl;
  score_t      s_next;
  logic [1:0]  alert;

  assign ctrl.upd = upd_q;
  assign ctrl.clr = inert_q;

  lgte_score_unit u_score (
    .ctrl       (ctrl),
    .score      (score[cnt]),
    .cond       (cond[cnt]),
    .dt         (dt_q),
    .leak       (leak_q),
    .dwell      (ver_dwell),
    .score_next (s_next),
    .alert      (alert)
  );

  // majority verdict
  logic [1:0] overall;

  always_comb begin
    if (over_cnt > under_cnt) begin
      overall = VERDICT_OVER;
    end else if (under_cnt > over_cnt) begin
      overall = VERDICT_UNDER;
    end else begin
      overall = VERDICT_NONE;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      zone_thr  <= THR_RESET;
      cap_dwell <= CAP_DWELL_RESET;
      ver_dwell <= VER_DWELL_RESET;
      axis      <= AXIS_RESET;
      bias      <= 16'sd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_ZONE_THR:  zone_thr  <= (cfg_data[14:0] < THR_MIN) ? THR_RESET : cfg_data[14:0];
        REG_CAP_DWELL: cap_dwell <= cfg_data;
        REG_VER_DWELL: ver_dwell <= cfg_data[14:0];
        REG_AXIS:      axis      <= cfg_data[1:0];
        REG_BIAS:      bias      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= S_IDLE;
      filt       <= 25'sd0;
      seeded     <= 1'b0;
      zone_timer <= 16'd0;
      capture    <= 1'b1;
      upd_q      <= 1'b0;
      inert_q    <= 1'b0;
      m_tvalid   <= 1'b0;
      for (int t = 0; t < TIRE_COUNT; t++) begin
        score[t] <= '0;
        cond[t]  <= COND_NEUTRAL;
      end
    end else begin
      // output register: load a finished word, drop valid once taken
      if (fsm == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {4'b0000, overall, alerts_acc >> ALERT_SHIFT, filt[24:8], capture};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (in_fire) begin
            track_q    <= track_mode;
            raw_q      <= raw;
            dt_q       <= dt_clamp;
            upd_q      <= 1'b0;
            inert_q    <= 1'b0;
            cnt        <= '0;
            alerts_acc <= 8'd0;
            over_cnt   <= 3'd0;
            under_cnt  <= 3'd0;
            if (kind == KIND_TICK) begin
              fsm <= S_MUL;
            end else begin
              if ({1'b0, tire_index} < 3'(TIRE_COUNT)) begin
                cond[tire_index[TIDX_W-1:0]] <= condition[1] ? COND_UNDER : condition;
              end
              fsm <= S_TIRE;
            end
          end
        end
        S_MUL: begin
          if (!seeded) begin
            filt   <= raw_q8;
            seeded <= 1'b1;
            fsm    <= S_ZONE;
          end else begin
            prod_q <= prod_full[32:0];
            fsm    <= S_FILT;
          end
        end
        S_FILT: begin
          filt <= filt + $signed(prod_q[32:8]);
          fsm  <= S_ZONE;
        end
        S_ZONE: begin
          if (!enable || !track_q) begin
            capture    <= 1'b1;
            zone_timer <= 16'd0;
            inert_q    <= 1'b1;
          end else begin
            capture    <= cap_next;
            zone_timer <= t_next;
            upd_q      <= cap_next;
            leak_q     <= leak_next;
          end
          fsm <= S_TIRE;
        end
        S_TIRE: begin
          score[cnt] <= s_next;
          if (inert_q) cond[cnt] <= COND_NEUTRAL;
          alerts_acc <= {alert, alerts_acc[7:2]};
          if (alert == VERDICT_OVER)  over_cnt  <= over_cnt + 3'd1;
          if (alert == VERDICT_UNDER) under_cnt <= under_cnt + 3'd1;
          if (cnt == LAST_TIRE) begin
            fsm <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            fsm <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/lgte_checker.sv
`default_nettype none

module lgte_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [lgte_pkg::OUT_W-1:0] m_tdata
);
  import lgte_pkg::*;

  // one word at a time: taking a word drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready stayed high after a word was taken");

  // out of reset the block is idle with nothing to show
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // verdict is never the unused code
  a_overall_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[27:26] != 2'd3)
    else $error("overall verdict carries an unused code");

  // a tire cannot be both over and under
  a_tire_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[19:18] != 2'd3 && m_tdata[21:20] != 2'd3 &&
                 m_tdata[23:22] != 2'd3 && m_tdata[25:24] != 2'd3)
    else $error("tire alert carries an unused code");

endmodule

bind lateral_gate_tire_evidence lgte_checker u_lgte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
